### hw/rtl/rlct_pkg.sv
// ----------------------------------------------------------------------------
// rlct_pkg
// Shared constants, types and helper functions for the run-length command
// tokenizer: token kinds, byte classes, queue sizes and the item formats.
// ----------------------------------------------------------------------------
package rlct_pkg;

  // Width of the internal run counter and of the run_count field
  localparam int COUNT_WIDTH     = 16;
  localparam int RUN_COUNT_WIDTH = 16;
  localparam int KIND_WIDTH      = 4;
  localparam int BYTE_WIDTH      = 8;

  // Token kinds
  localparam logic [KIND_WIDTH-1:0] KIND_RIGHT      = 4'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_LEFT       = 4'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_OUTPUT     = 4'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_INPUT      = 4'd3;
  localparam logic [KIND_WIDTH-1:0] KIND_INC        = 4'd4;
  localparam logic [KIND_WIDTH-1:0] KIND_DEC        = 4'd5;
  localparam logic [KIND_WIDTH-1:0] KIND_LOOP_START = 4'd6;
  localparam logic [KIND_WIDTH-1:0] KIND_LOOP_END   = 4'd7;
  localparam logic [KIND_WIDTH-1:0] KIND_COMMENT    = 4'd8;
  localparam logic [KIND_WIDTH-1:0] KIND_END        = 4'd9;

  // Byte classes beyond the token kinds
  localparam logic [KIND_WIDTH-1:0] CLASS_NEWLINE = 4'd10;
  localparam logic [KIND_WIDTH-1:0] CLASS_START   = 4'd15;

  // Input actions
  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_END  = 1'b1;

  // Source characters
  localparam logic [BYTE_WIDTH-1:0] CHAR_RIGHT      = 8'h3E;  // >
  localparam logic [BYTE_WIDTH-1:0] CHAR_LEFT       = 8'h3C;  // <
  localparam logic [BYTE_WIDTH-1:0] CHAR_OUTPUT     = 8'h2E;  // .
  localparam logic [BYTE_WIDTH-1:0] CHAR_INPUT      = 8'h2C;  // ,
  localparam logic [BYTE_WIDTH-1:0] CHAR_INC        = 8'h2B;  // +
  localparam logic [BYTE_WIDTH-1:0] CHAR_DEC        = 8'h2D;  // -
  localparam logic [BYTE_WIDTH-1:0] CHAR_LOOP_START = 8'h5B;  // [
  localparam logic [BYTE_WIDTH-1:0] CHAR_LOOP_END   = 8'h5D;  // ]
  localparam logic [BYTE_WIDTH-1:0] CHAR_NEWLINE    = 8'h0A;

  // Command queue between front and back
  localparam int CMD_PTR_WIDTH = 2;
  localparam int CMD_DEPTH     = 1 << CMD_PTR_WIDTH;
  localparam int CMD_CNT_WIDTH = CMD_PTR_WIDTH + 1;

  // Token buffer at the output
  localparam int TOK_PTR_WIDTH = 2;
  localparam int TOK_DEPTH     = 1 << TOK_PTR_WIDTH;
  localparam int TOK_CNT_WIDTH = TOK_PTR_WIDTH + 1;

  // Classified command handed from front to back
  typedef struct packed {
    logic                  is_end;
    logic [KIND_WIDTH-1:0] cls;
  } cmd_t;

  // One emitted token
  typedef struct packed {
    logic [KIND_WIDTH-1:0]      kind;
    logic [RUN_COUNT_WIDTH-1:0] count;
    logic                       last;
  } token_t;

  // Map a source byte to its class
  function automatic logic [KIND_WIDTH-1:0] classify(input logic [BYTE_WIDTH-1:0] b);
    logic [KIND_WIDTH-1:0] c;
    case (b)
      CHAR_RIGHT:      c = KIND_RIGHT;
      CHAR_LEFT:       c = KIND_LEFT;
      CHAR_OUTPUT:     c = KIND_OUTPUT;
      CHAR_INPUT:      c = KIND_INPUT;
      CHAR_INC:        c = KIND_INC;
      CHAR_DEC:        c = KIND_DEC;
      CHAR_LOOP_START: c = KIND_LOOP_START;
      CHAR_LOOP_END:   c = KIND_LOOP_END;
      CHAR_NEWLINE:    c = CLASS_NEWLINE;
      default:         c = KIND_COMMENT;
    endcase
    return c;
  endfunction

  // Low bits of a run counter as carried in run_count
  function automatic logic [RUN_COUNT_WIDTH-1:0] run_count_of(
      input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH+RUN_COUNT_WIDTH-1:0] wide;
    wide = {{RUN_COUNT_WIDTH{1'b0}}, c};
    return wide[RUN_COUNT_WIDTH-1:0];
  endfunction

endpackage

### hw/rtl/rlct_if.sv
// ----------------------------------------------------------------------------
// rlct_if
// Valid/ready channels of the tokenizer: the source input and the token
// output, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface rlct_in_if;
  import rlct_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [BYTE_WIDTH-1:0] source_byte;

  modport source (output valid, output action, output source_byte, input ready);
  modport sink   (input valid, input action, input source_byte, output ready);
endinterface

interface rlct_out_if;
  import rlct_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [KIND_WIDTH-1:0]      token_kind;
  logic [RUN_COUNT_WIDTH-1:0] run_count;
  logic                       last_of_run;

  modport source (output valid, output token_kind, output run_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input run_count,
                  input last_of_run, output ready);
endinterface

### hw/rtl/rlct_front.sv
// ----------------------------------------------------------------------------
// rlct_front
// Accepts source items and classifies each byte into a command for the
// command queue.
// ----------------------------------------------------------------------------
module rlct_front (
  rlct_in_if.sink         in,
  input  logic            cmd_full,
  output logic            cmd_push,
  output rlct_pkg::cmd_t  cmd_data
);
  import rlct_pkg::*;

  // Take an item whenever the queue has room
  assign in.ready = !cmd_full;
  assign cmd_push = in.valid && !cmd_full;

  // Classify the byte; an end item carries CLASS_START in place of a class
  always_comb begin
    cmd_data.is_end = (in.action == ACTION_END);
    cmd_data.cls    = (in.action == ACTION_END) ? CLASS_START : classify(in.source_byte);
  end

endmodule

### hw/rtl/rlct_queue.sv
// ----------------------------------------------------------------------------
// rlct_queue
// Short command queue between front and back so that each side stalls on
// its own.
// ----------------------------------------------------------------------------
module rlct_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rlct_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output rlct_pkg::cmd_t  pop_data
);
  import rlct_pkg::*;

  cmd_t                     mem [CMD_DEPTH];
  logic [CMD_PTR_WIDTH-1:0] wr_ptr;
  logic [CMD_PTR_WIDTH-1:0] rd_ptr;
  logic [CMD_CNT_WIDTH-1:0] count;
  logic                     do_push;
  logic                     do_pop;

  assign full      = (count == CMD_CNT_WIDTH'(CMD_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + CMD_PTR_WIDTH'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + CMD_PTR_WIDTH'(1);
      end
      count <= count + CMD_CNT_WIDTH'(do_push) - CMD_CNT_WIDTH'(do_pop);
    end
  end

endmodule

### hw/rtl/rlct_back.sv
// ----------------------------------------------------------------------------
// rlct_back
// Carries out classified commands: merges runs, flushes held tokens and
// writes up to two tokens per command into a small output buffer.
// ----------------------------------------------------------------------------
module rlct_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  rlct_pkg::cmd_t  cmd_data,
  output logic            cmd_pop,
  rlct_out_if.source      out
);
  import rlct_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Run state
  logic [KIND_WIDTH-1:0]  prev_class, prev_class_next;
  logic                   pend_valid, pend_valid_next;
  logic [KIND_WIDTH-1:0]  pend_kind, pend_kind_next;
  logic [COUNT_WIDTH-1:0] pend_count, pend_count_next;

  // Results of the current command
  token_t     res0, res1;
  logic [1:0] res_n;

  // Output buffer
  token_t                   tok_mem [TOK_DEPTH];
  logic [TOK_PTR_WIDTH-1:0] wr_ptr, rd_ptr, wr_ptr_1;
  logic [TOK_CNT_WIDTH-1:0] tok_count;
  logic                     out_pop;
  logic                     can_take;

  token_t held_tok;
  logic   is_single;
  logic   is_match;

  // Room for two more tokens regardless of the sink
  assign can_take = (tok_count <= TOK_CNT_WIDTH'(TOK_DEPTH - 2));
  assign cmd_pop  = cmd_valid && can_take;

  assign held_tok.kind  = pend_kind;
  assign held_tok.count = run_count_of(pend_count);
  assign held_tok.last  = 1'b0;

  assign is_single = (cmd_data.cls inside {KIND_OUTPUT, KIND_INPUT,
                                           KIND_LOOP_START, KIND_LOOP_END});
  assign is_match  = pend_valid && (prev_class == cmd_data.cls) &&
                     (pend_kind == cmd_data.cls);

  // Decide results and next run state
  always_comb begin
    prev_class_next = prev_class;
    pend_valid_next = pend_valid;
    pend_kind_next  = pend_kind;
    pend_count_next = pend_count;
    res0            = held_tok;
    res1            = held_tok;
    res_n           = 2'd0;

    if (cmd_data.is_end) begin
      // Flush, then the end token; return to start
      res1.kind  = KIND_END;
      res1.count = RUN_COUNT_WIDTH'(1);
      res1.last  = 1'b1;
      if (pend_valid) begin
        res_n = 2'd2;
      end else begin
        res0  = res1;
        res_n = 2'd1;
      end
      prev_class_next = CLASS_START;
      pend_valid_next = 1'b0;
      pend_kind_next  = '0;
      pend_count_next = '0;
    end else if (cmd_data.cls == CLASS_NEWLINE) begin
      // Break any run
      res0.last       = 1'b1;
      res_n           = pend_valid ? 2'd1 : 2'd0;
      pend_valid_next = 1'b0;
      prev_class_next = cmd_data.cls;
    end else if (is_single) begin
      // Flush, then the command token on its own
      res1.kind  = cmd_data.cls;
      res1.count = RUN_COUNT_WIDTH'(1);
      res1.last  = 1'b1;
      if (pend_valid) begin
        res_n = 2'd2;
      end else begin
        res0  = res1;
        res_n = 2'd1;
      end
      pend_valid_next = 1'b0;
      prev_class_next = cmd_data.cls;
    end else if (is_match) begin
      // Extend the run; emit and restart when the count is full
      if (pend_count == COUNT_MAX) begin
        res0.last       = 1'b1;
        res_n           = 2'd1;
        pend_count_next = COUNT_WIDTH'(1);
      end else begin
        pend_count_next = pend_count + COUNT_WIDTH'(1);
      end
      prev_class_next = cmd_data.cls;
    end else begin
      // Flush and start a new run
      res0.last       = 1'b1;
      res_n           = pend_valid ? 2'd1 : 2'd0;
      pend_valid_next = 1'b1;
      pend_kind_next  = cmd_data.cls;
      pend_count_next = COUNT_WIDTH'(1);
      prev_class_next = cmd_data.cls;
    end
  end

  // Hold run state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_class <= CLASS_START;
      pend_valid <= 1'b0;
      pend_kind  <= '0;
      pend_count <= '0;
    end else if (cmd_pop) begin
      prev_class <= prev_class_next;
      pend_valid <= pend_valid_next;
      pend_kind  <= pend_kind_next;
      pend_count <= pend_count_next;
    end
  end

  // Output buffer
  assign wr_ptr_1        = wr_ptr + TOK_PTR_WIDTH'(1);
  assign out.valid       = (tok_count != '0);
  assign out.token_kind  = tok_mem[rd_ptr].kind;
  assign out.run_count   = tok_mem[rd_ptr].count;
  assign out.last_of_run = tok_mem[rd_ptr].last;
  assign out_pop         = out.valid && out.ready;

  always_ff @(posedge clk) begin
    if (cmd_pop && (res_n != 2'd0)) begin
      tok_mem[wr_ptr] <= res0;
    end
    if (cmd_pop && (res_n == 2'd2)) begin
      tok_mem[wr_ptr_1] <= res1;
    end
  end

  // Advance buffer pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      tok_count <= '0;
    end else begin
      if (cmd_pop) begin
        wr_ptr <= wr_ptr + TOK_PTR_WIDTH'(res_n);
      end
      if (out_pop) begin
        rd_ptr <= rd_ptr + TOK_PTR_WIDTH'(1);
      end
      tok_count <= tok_count + (cmd_pop ? TOK_CNT_WIDTH'(res_n) : '0)
                 - TOK_CNT_WIDTH'(out_pop);
    end
  end

endmodule

### hw/rtl/run_length_command_tokenizer_top.sv
// ----------------------------------------------------------------------------
// run_length_command_tokenizer_top
// Tokenizes a byte stream of command characters into run-length tokens.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one item per source byte (action 0) or end of source (action 1),
//         accepted when valid and ready are high at a clock edge.
//   out : tokens with kind, run count and last_of_run, which marks the final
//         token caused by one input item.
// The front classifies each byte and pushes it into a four-entry command
// queue; the back merges runs and writes tokens into a four-entry output
// buffer. At most one item is accepted per cycle, while the queue has room.
// An item that produces a token is registered in the queue and then in the
// output buffer before the token shows on out.
// Items that give two tokens (flush plus a new token) leave as two tokens
// through the single output port, which bounds the sustained rate of at
// most one item per cycle.
// When the receiver stalls the output buffer fills, the back stops taking
// commands, the queue fills and the front drops ready on in. A held run is
// sent only when its run ends, its count is full or an end item arrives.
// Reset (rst, synchronous) clears the queue, the buffer and any held run.
// ----------------------------------------------------------------------------
module run_length_command_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  rlct_in_if.sink     in,
  rlct_out_if.source  out
);
  import rlct_pkg::*;

  logic cmd_full;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_valid;
  cmd_t cmd_out;
  logic cmd_pop;

  rlct_front u_front (
    .in       (in),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in)
  );

  rlct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_valid (cmd_valid),
    .pop_data  (cmd_out)
  );

  rlct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .out       (out)
  );

endmodule
